@@ hw/rtl/console_line_editor_defines.svh @@
// assertion macros for the console line editor
// no dependencies; included by the top level only
`ifndef CONSOLE_LINE_EDITOR_DEFINES_SVH
`define CONSOLE_LINE_EDITOR_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define CLE_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define CLE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/cle_pkg.sv @@
// shared types and constants for the console line editor
// no dependencies; used by the front end, queue, back end and top level
package cle_pkg;

    // command codes
    localparam logic [1:0] CMD_BYTE    = 2'd0;
    localparam logic [1:0] CMD_READ    = 2'd1;
    localparam logic [1:0] CMD_BACK    = 2'd2;
    localparam logic [1:0] CMD_DISCARD = 2'd3;

    // status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_NO_LINE = 2'd1;
    localparam logic [1:0] STAT_FULL    = 2'd2;
    localparam logic [1:0] STAT_BUSY    = 2'd3;

    // keyboard bytes
    localparam logic [7:0] K_BS      = 8'h08;
    localparam logic [7:0] K_TAB     = 8'h09;
    localparam logic [7:0] K_NL      = 8'h0A;
    localparam logic [7:0] K_CR      = 8'h0D;
    localparam logic [7:0] K_CTRL_R  = 8'h12;
    localparam logic [7:0] K_CTRL_U  = 8'h15;
    localparam logic [7:0] K_CTRL_W  = 8'h17;
    localparam logic [7:0] K_SP      = 8'h20;
    localparam logic [7:0] K_R       = 8'h52;
    localparam logic [7:0] K_CARET   = 8'h5E;
    localparam logic [7:0] K_DEL     = 8'h7F;
    localparam logic [7:0] CTRL_FLIP = 8'h40;

    // echo packing
    localparam logic [3:0] ECHO_FULL   = 4'd8;
    localparam int         MAX_RESULTS = 48;
    localparam int         SPILL_W     = $clog2(MAX_RESULTS);

    // front to back queue
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] in_byte;
        logic       skip_blanks;
    } t_in_item;

    typedef struct packed {
        logic [63:0] echo_data;
        logic [3:0]  echo_count;
        logic [7:0]  read_char;
        logic        line_ready;
        logic [1:0]  status;
        logic        last;
    } t_out_item;

    typedef enum logic [2:0] {
        OP_STORE,
        OP_ERASE1,
        OP_KILL,
        OP_REPRINT,
        OP_WERASE,
        OP_READ,
        OP_BACK,
        OP_DISCARD
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] data;
        logic       skip;
    } t_op_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_E1,
        S_E2,
        S_E3,
        S_WREAD,
        S_WTEST,
        S_RPRD,
        S_RPWR,
        S_RDNEXT,
        S_RDWAIT,
        S_DONE
    } t_state;

endpackage

@@ hw/rtl/cle_ram.sv @@
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module cle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/cle_front.sv @@
// front end: takes commands, classifies them into operations for the back end
// depends on cle_pkg
module cle_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  cle_pkg::t_in_item i_item,
    input  logic              i_q_full,
    output logic              o_busy,
    output logic              o_push,
    output cle_pkg::t_op_item o_entry
);

    logic              r_valid;
    logic              n_valid;
    cle_pkg::t_op_item r_entry;
    cle_pkg::t_op_item w_class;
    logic              w_accept;

    always_comb begin
        w_class.data = i_item.in_byte;
        w_class.skip = i_item.skip_blanks;
        case (i_item.cmd)
            cle_pkg::CMD_BYTE: begin
                case (i_item.in_byte)
                    cle_pkg::K_BS, cle_pkg::K_DEL: w_class.op = cle_pkg::OP_ERASE1;
                    cle_pkg::K_CTRL_U:             w_class.op = cle_pkg::OP_KILL;
                    cle_pkg::K_CTRL_R:             w_class.op = cle_pkg::OP_REPRINT;
                    cle_pkg::K_CTRL_W:             w_class.op = cle_pkg::OP_WERASE;
                    default:                       w_class.op = cle_pkg::OP_STORE;
                endcase
            end
            cle_pkg::CMD_READ: w_class.op = cle_pkg::OP_READ;
            cle_pkg::CMD_BACK: w_class.op = cle_pkg::OP_BACK;
            // discard line
            default:           w_class.op = cle_pkg::OP_DISCARD;
        endcase
    end

    assign o_busy   = r_valid && i_q_full;
    assign w_accept = i_start && !o_busy;
    assign o_push   = r_valid && !i_q_full;
    assign o_entry  = r_entry;

    always_comb begin
        n_valid = r_valid;
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_entry <= w_class;
        end
    end

endmodule

@@ hw/rtl/cle_queue.sv @@
// short fifo of classified operations between front and back end
// depends on cle_pkg
module cle_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  cle_pkg::t_op_item i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_empty,
    output cle_pkg::t_op_item o_data
);

    localparam int PW = (cle_pkg::QUEUE_DEPTH > 1) ? $clog2(cle_pkg::QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(cle_pkg::QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(cle_pkg::QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(cle_pkg::QUEUE_DEPTH);

    cle_pkg::t_op_item r_mem [cle_pkg::QUEUE_DEPTH];
    logic [PW-1:0]     r_wptr, n_wptr;
    logic [PW-1:0]     r_rptr, n_rptr;
    logic [CW-1:0]     r_count, n_count;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == PTR_LAST) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == PTR_LAST) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

@@ hw/rtl/cle_back.sv @@
// back end: line buffer, edit sequencer and echo packing
// depends on cle_pkg and cle_ram
module cle_back #(
    parameter int LINE_DEPTH = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    input  cle_pkg::t_op_item  i_q_data,
    output logic               o_pop,
    output logic               o_strobe,
    output cle_pkg::t_out_item o_result
);

    localparam int AW = $clog2(LINE_DEPTH);
    localparam int FW = $clog2(LINE_DEPTH + 1);
    localparam logic [FW-1:0] FILL_MAX = FW'(LINE_DEPTH);
    localparam logic [cle_pkg::SPILL_W-1:0] SPILL_LAST =
        cle_pkg::SPILL_W'(cle_pkg::MAX_RESULTS - 1);

    cle_pkg::t_state    r_state, n_state;
    cle_pkg::t_op       r_op, n_op;
    logic [7:0]         r_data, n_data;
    logic               r_skip, n_skip;
    logic [FW-1:0]      r_fill, n_fill;
    logic [FW-1:0]      r_rp, n_rp;
    logic [FW-1:0]      r_idx, n_idx;
    logic               r_complete, n_complete;
    logic               r_word, n_word;
    logic [1:0]         r_status, n_status;
    logic [7:0]         r_rc, n_rc;
    logic [63:0]        r_acc, n_acc;
    logic [3:0]         r_cnt, n_cnt;
    logic [cle_pkg::SPILL_W-1:0] r_nspill, n_nspill;
    logic               r_strobe, n_strobe;
    cle_pkg::t_out_item r_out, n_out;

    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [7:0]    w_wdata;
    logic          w_re;
    logic [AW-1:0] w_raddr;
    logic [7:0]    w_rdata;

    logic          w_app;
    logic [7:0]    w_app_byte;
    logic [FW-1:0] w_fill_m1;
    logic          w_fill_zero;
    logic          w_rd_blank;
    logic          w_rd_space;
    logic          w_show_caret;

    cle_ram #(
        .WIDTH (8),
        .DEPTH (LINE_DEPTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_fill_m1    = r_fill - 1'b1;
    assign w_fill_zero  = (r_fill == '0);
    assign w_rd_blank   = (w_rdata == cle_pkg::K_SP) ||
                          (w_rdata inside {[cle_pkg::K_TAB:cle_pkg::K_CR]});
    assign w_rd_space   = (w_rdata == cle_pkg::K_SP) || (w_rdata == cle_pkg::K_TAB);
    assign w_show_caret = (r_data < cle_pkg::K_SP) && (r_data != cle_pkg::K_TAB) &&
                          (r_data != cle_pkg::K_NL);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            cle_pkg::S_IDLE: begin
                if (!i_q_empty) begin
                    n_state = cle_pkg::S_DECIDE;
                end
            end
            cle_pkg::S_DECIDE: begin
                case (r_op)
                    cle_pkg::OP_ERASE1, cle_pkg::OP_KILL: begin
                        n_state = (r_complete || w_fill_zero) ? cle_pkg::S_DONE : cle_pkg::S_E1;
                    end
                    cle_pkg::OP_WERASE: begin
                        n_state = r_complete ? cle_pkg::S_DONE : cle_pkg::S_WREAD;
                    end
                    cle_pkg::OP_REPRINT: begin
                        n_state = r_complete ? cle_pkg::S_DONE : cle_pkg::S_RPRD;
                    end
                    cle_pkg::OP_READ: begin
                        n_state = r_complete ? cle_pkg::S_RDNEXT : cle_pkg::S_DONE;
                    end
                    default: n_state = cle_pkg::S_DONE;
                endcase
            end
            cle_pkg::S_E1: n_state = cle_pkg::S_E2;
            cle_pkg::S_E2: n_state = cle_pkg::S_E3;
            cle_pkg::S_E3: begin
                case (r_op)
                    cle_pkg::OP_KILL: begin
                        n_state = (w_fill_m1 == '0) ? cle_pkg::S_DONE : cle_pkg::S_E1;
                    end
                    cle_pkg::OP_WERASE: n_state = cle_pkg::S_WREAD;
                    default:            n_state = cle_pkg::S_DONE;
                endcase
            end
            cle_pkg::S_WREAD: begin
                n_state = w_fill_zero ? cle_pkg::S_DONE : cle_pkg::S_WTEST;
            end
            cle_pkg::S_WTEST: begin
                // word phase ends at the first blank before the word
                n_state = (r_word && w_rd_blank) ? cle_pkg::S_DONE : cle_pkg::S_E1;
            end
            cle_pkg::S_RPRD: begin
                n_state = (r_idx < r_fill) ? cle_pkg::S_RPWR : cle_pkg::S_DONE;
            end
            cle_pkg::S_RPWR: n_state = cle_pkg::S_RPRD;
            cle_pkg::S_RDNEXT: begin
                n_state = (r_rp < r_fill) ? cle_pkg::S_RDWAIT : cle_pkg::S_DONE;
            end
            cle_pkg::S_RDWAIT: begin
                n_state = (r_skip && w_rd_space) ? cle_pkg::S_RDNEXT : cle_pkg::S_DONE;
            end
            cle_pkg::S_DONE: n_state = cle_pkg::S_IDLE;
            default:         n_state = cle_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_op       = r_op;
        n_data     = r_data;
        n_skip     = r_skip;
        n_fill     = r_fill;
        n_rp       = r_rp;
        n_idx      = r_idx;
        n_complete = r_complete;
        n_word     = r_word;
        n_status   = r_status;
        n_rc       = r_rc;
        n_acc      = r_acc;
        n_cnt      = r_cnt;
        n_nspill   = r_nspill;
        n_strobe   = 1'b0;
        n_out      = r_out;
        o_pop      = 1'b0;
        w_we       = 1'b0;
        w_waddr    = r_fill[AW-1:0];
        w_wdata    = r_data;
        w_re       = 1'b0;
        w_raddr    = '0;
        w_app      = 1'b0;
        w_app_byte = cle_pkg::K_BS;

        case (r_state)
            cle_pkg::S_IDLE: begin
                if (!i_q_empty) begin
                    o_pop    = 1'b1;
                    n_op     = i_q_data.op;
                    n_data   = i_q_data.data;
                    n_skip   = i_q_data.skip;
                    n_status = cle_pkg::STAT_OK;
                    n_rc     = '0;
                end
            end
            cle_pkg::S_DECIDE: begin
                case (r_op)
                    cle_pkg::OP_STORE: begin
                        if (r_complete) begin
                            n_status = cle_pkg::STAT_BUSY;
                        end else if (r_fill == FILL_MAX) begin
                            n_status = cle_pkg::STAT_FULL;
                        end else begin
                            w_we   = 1'b1;
                            n_fill = r_fill + 1'b1;
                            if (w_show_caret) begin
                                n_acc = {48'b0, r_data ^ cle_pkg::CTRL_FLIP, cle_pkg::K_CARET};
                                n_cnt = 4'd2;
                            end else begin
                                n_acc = {56'b0, r_data};
                                n_cnt = 4'd1;
                            end
                            if (r_data == cle_pkg::K_NL) begin
                                n_complete = 1'b1;
                                n_rp       = '0;
                            end
                        end
                    end
                    cle_pkg::OP_ERASE1, cle_pkg::OP_KILL: begin
                        if (r_complete) begin
                            n_status = cle_pkg::STAT_BUSY;
                        end
                    end
                    cle_pkg::OP_WERASE: begin
                        n_word = 1'b0;
                        if (r_complete) begin
                            n_status = cle_pkg::STAT_BUSY;
                        end
                    end
                    cle_pkg::OP_REPRINT: begin
                        if (r_complete) begin
                            n_status = cle_pkg::STAT_BUSY;
                        end else begin
                            n_acc = {40'b0, cle_pkg::K_NL, cle_pkg::K_R, cle_pkg::K_CARET};
                            n_cnt = 4'd3;
                            n_idx = '0;
                        end
                    end
                    cle_pkg::OP_READ: begin
                        if (!r_complete) begin
                            n_status = cle_pkg::STAT_NO_LINE;
                        end
                    end
                    cle_pkg::OP_BACK: begin
                        if (!r_complete) begin
                            n_status = cle_pkg::STAT_NO_LINE;
                        end else if (r_rp != '0) begin
                            n_rp = r_rp - 1'b1;
                        end
                    end
                    default: begin
                        // discard line
                        n_complete = 1'b0;
                        n_fill     = '0;
                        n_rp       = '0;
                    end
                endcase
            end
            cle_pkg::S_E1: begin
                w_app = 1'b1;
            end
            cle_pkg::S_E2: begin
                w_app      = 1'b1;
                w_app_byte = cle_pkg::K_SP;
            end
            cle_pkg::S_E3: begin
                w_app  = 1'b1;
                n_fill = w_fill_m1;
            end
            cle_pkg::S_WREAD: begin
                w_re    = !w_fill_zero;
                w_raddr = w_fill_m1[AW-1:0];
            end
            cle_pkg::S_WTEST: begin
                n_word = r_word || !w_rd_blank;
            end
            cle_pkg::S_RPRD: begin
                if (r_idx < r_fill) begin
                    w_re    = 1'b1;
                    w_raddr = r_idx[AW-1:0];
                    n_idx   = r_idx + 1'b1;
                end
            end
            cle_pkg::S_RPWR: begin
                w_app      = 1'b1;
                w_app_byte = w_rdata;
            end
            cle_pkg::S_RDNEXT: begin
                if (r_rp < r_fill) begin
                    w_re    = 1'b1;
                    w_raddr = r_rp[AW-1:0];
                    n_rp    = r_rp + 1'b1;
                end else begin
                    n_rc = '0;
                end
            end
            cle_pkg::S_RDWAIT: begin
                n_rc = w_rdata;
            end
            cle_pkg::S_DONE: begin
                n_strobe         = 1'b1;
                n_out.echo_data  = r_acc;
                n_out.echo_count = r_cnt;
                n_out.read_char  = r_rc;
                n_out.line_ready = r_complete;
                n_out.status     = r_status;
                n_out.last       = 1'b1;
                n_acc            = '0;
                n_cnt            = '0;
                n_nspill         = '0;
            end
            default: begin
                n_strobe = 1'b0;
            end
        endcase

        // the next echo byte sends a full group, if spills remain
        if (w_app) begin
            if (r_cnt == cle_pkg::ECHO_FULL) begin
                if (r_nspill != SPILL_LAST) begin
                    n_strobe         = 1'b1;
                    n_out.echo_data  = r_acc;
                    n_out.echo_count = r_cnt;
                    n_out.read_char  = '0;
                    n_out.line_ready = r_complete;
                    n_out.status     = r_status;
                    n_out.last       = 1'b0;
                    n_acc            = {56'b0, w_app_byte};
                    n_cnt            = 4'd1;
                    n_nspill         = r_nspill + 1'b1;
                end
            end else begin
                n_acc[{r_cnt[2:0], 3'b000} +: 8] = w_app_byte;
                n_cnt = r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= cle_pkg::S_IDLE;
            r_fill     <= '0;
            r_rp       <= '0;
            r_complete <= 1'b0;
            r_acc      <= '0;
            r_cnt      <= '0;
            r_nspill   <= '0;
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_fill     <= n_fill;
            r_rp       <= n_rp;
            r_complete <= n_complete;
            r_acc      <= n_acc;
            r_cnt      <= n_cnt;
            r_nspill   <= n_nspill;
            r_strobe   <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_data   <= n_data;
        r_skip   <= n_skip;
        r_idx    <= n_idx;
        r_word   <= n_word;
        r_status <= n_status;
        r_rc     <= n_rc;
        r_out    <= n_out;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_out;

endmodule

@@ hw/rtl/console_line_editor.sv @@
// console line editor top level: front end, operation queue and back end
// depends on cle_pkg, cle_front, cle_queue, cle_back and the assertion macro header
//
// Commands are taken when start is high and busy is low; busy rises only when the
// front register and the two-entry operation queue are all occupied. Results leave
// on o_result for one cycle each, marked by o_strobe, and cannot be held off, so
// the receiver must take every strobed result. A taken command passes the front
// register and the operation queue to the back end, where every command takes
// IDLE, DECIDE and DONE; an erased character adds E1, E2 and E3 (one per echo
// byte), Ctrl-W adds WREAD, WTEST per examined character, Ctrl-R adds RPRD, RPWR
// per reprinted character, and a read adds RDNEXT and RDWAIT (only RDNEXT at the
// line end), both again per skipped blank. The per character steps come from the
// line buffer RAM's one registered read port and one echo byte packed per cycle.
`include "console_line_editor_defines.svh"

module console_line_editor #(
    parameter int LINE_DEPTH = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  cle_pkg::t_in_item  i_item,
    output logic               o_strobe,
    output cle_pkg::t_out_item o_result
);

    logic              w_push;
    logic              w_q_full;
    logic              w_q_empty;
    logic              w_pop;
    cle_pkg::t_op_item w_entry;
    cle_pkg::t_op_item w_q_data;

    cle_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_item   (i_item),
        .i_q_full (w_q_full),
        .o_busy   (busy),
        .o_push   (w_push),
        .o_entry  (w_entry)
    );

    cle_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_entry),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_empty (w_q_empty),
        .o_data  (w_q_data)
    );

    cle_back #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (w_q_empty),
        .i_q_data  (w_q_data),
        .o_pop     (w_pop),
        .o_strobe  (o_strobe),
        .o_result  (o_result)
    );

    // only the final result of a command may carry a partial echo group
    `CLE_ASSERT_IMPLY(a_spill_full, i_clk, i_rst_n, o_strobe && !o_result.last, o_result.echo_count == cle_pkg::ECHO_FULL, "non-final result without a full echo group")
    // refused commands echo nothing and return no character
    `CLE_ASSERT_IMPLY(a_refused_quiet, i_clk, i_rst_n, o_strobe && (o_result.status != cle_pkg::STAT_OK), (o_result.echo_count == 4'd0) && (o_result.read_char == 8'd0), "refused command produced echo or data")
    // a byte is dropped as busy only while a completed line is held
    `CLE_ASSERT_IMPLY(a_busy_line, i_clk, i_rst_n, o_strobe && (o_result.status == cle_pkg::STAT_BUSY), o_result.line_ready, "busy drop without a held line")
    // a transfer from the front stage always lands in the queue
    `CLE_ASSERT_NEXT(a_push_lands, i_clk, i_rst_n, w_push, !w_q_empty, "pushed operation missing from queue")

endmodule
